### rtl/mkd_pkg.sv
// Shared widths, pin constants and reset values for the keypad debouncer.
package mkd_pkg;

    localparam int PINS_W     = 3;
    localparam int TIME_W     = 32;
    localparam int TICKS_W    = 31;
    localparam int MASK_W     = 6;
    localparam int NUM_KEYS_DEF = 6;

    localparam logic [PINS_W-1:0]  PIN_A = 3'(1 << 0);
    localparam logic [PINS_W-1:0]  PIN_B = 3'(1 << 1);
    localparam logic [PINS_W-1:0]  PIN_C = 3'(1 << 2);

    localparam logic [TICKS_W-1:0] TICKS_RESET = 31'd20;

    typedef logic [PINS_W-1:0]  t_pins;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [TICKS_W-1:0] t_ticks;
    typedef logic [MASK_W-1:0]  t_mask;

    // Active-low pins: a low pin sets its bit of the code.
    function automatic t_pins pin_code(input t_pins pins);
        t_pins code;
        code = '0;
        if ((pins & PIN_A) == '0) code = code | PIN_A;
        if ((pins & PIN_B) == '0) code = code | PIN_B;
        if ((pins & PIN_C) == '0) code = code | PIN_C;
        return code;
    endfunction

endpackage

### rtl/mkd_item_if.sv
// Scan sample channel: raw mux pins and tick time.
interface mkd_item_if;
    import mkd_pkg::*;
    logic  valid;
    logic  ready;
    t_pins mux_pins;
    t_time now_time;

    modport source (output valid, output mux_pins, output now_time, input ready);
    modport sink   (input valid, input mux_pins, input now_time, output ready);
endinterface

### rtl/mkd_result_if.sv
// Result channel: debounced key mask.
interface mkd_result_if;
    import mkd_pkg::*;
    logic  valid;
    logic  ready;
    t_mask pressed_mask;

    modport source (output valid, output pressed_mask, input ready);
    modport sink   (input valid, input pressed_mask, output ready);
endinterface

### rtl/mkd_cfg_if.sv
// Configuration write channel for the debounce setting.
interface mkd_cfg_if;
    import mkd_pkg::*;
    logic   valid;
    logic   ready;
    t_ticks data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/mkd_key_cell.sv
// Debounce state and update logic for one key.
module mkd_key_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_raw,
    input  mkd_pkg::t_time  i_now,
    input  mkd_pkg::t_ticks i_ticks,
    output logic           o_next_closed
);
    import mkd_pkg::*;

    logic  r_closed, n_closed;
    logic  r_pending, n_pending;
    t_time r_start, n_start;
    t_time w_diff;
    t_time w_mag;
    logic  w_reached;

    // Signed distance; the most negative value maps to 2^31 unsigned.
    assign w_diff    = i_now - r_start;
    assign w_mag     = w_diff[TIME_W-1] ? (t_time'(0) - w_diff) : w_diff;
    assign w_reached = (w_mag >= {1'b0, i_ticks});

    always_comb begin
        n_closed  = r_closed;
        n_pending = r_pending;
        n_start   = r_start;
        if (i_en) begin
            if (i_raw != r_closed) begin
                if (r_pending) begin
                    if (w_reached) begin
                        n_closed  = ~r_closed;
                        n_pending = 1'b0;
                    end
                end else begin
                    n_start   = i_now;
                    n_pending = 1'b1;
                end
            end else begin
                n_pending = 1'b0;
            end
        end
    end

    assign o_next_closed = n_closed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed  <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            r_closed  <= n_closed;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

endmodule

### rtl/muxed_keypad_debouncer_core.sv
// Keypad debouncer: scan samples in, debounced key mask out, one result per sample.
// Takes one sample per clock while results are taken; returns one mask per sample, in order.
// A sample goes into an input register, is decoded, updates all key states in parallel,
// and its mask lands in the result register when the held sample advances, which waits
// while a result is held unaccepted. The input and result registers decouple the two
// sides, so a new sample is taken every cycle while the result side keeps pace. Pins
// are active low; code c from 1 to NUM_KEYS closes key c-1. A raw change must persist for
// at least debounce_ticks ticks (signed 32-bit wrap-aware distance) before the key toggles.
// Write the setting only while no sample is in flight; the write port is always ready.
module muxed_keypad_debouncer_core #(
    parameter int NUM_KEYS = mkd_pkg::NUM_KEYS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mkd_item_if.sink     i_item,
    mkd_result_if.source o_result,
    mkd_cfg_if.sink      i_cfg
);
    import mkd_pkg::*;

    localparam int PAD_W = (NUM_KEYS > MASK_W) ? NUM_KEYS : MASK_W;

    t_ticks r_ticks;
    logic   r_in_valid;
    t_pins  r_pins;
    t_time  r_time;
    logic   r_out_valid;
    t_mask  r_mask;
    t_mask  n_mask;

    logic   w_advance;
    t_pins  w_code;
    logic [NUM_KEYS-1:0] w_next;
    logic [PAD_W-1:0]    w_next_pad;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICKS_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_ticks <= i_cfg.data;
        end
    end

    // Advance the held sample when the result register is free or draining.
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_pins <= i_item.mux_pins;
            r_time <= i_item.now_time;
        end
    end

    assign w_code = pin_code(r_pins);

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        mkd_key_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (w_advance),
            .i_raw         (w_code == PINS_W'(k + 1)),
            .i_now         (r_time),
            .i_ticks       (r_ticks),
            .o_next_closed (w_next[k])
        );
    end

    // Keys beyond the mask width are tracked but not reported.
    assign w_next_pad = PAD_W'(w_next);
    assign n_mask     = w_next_pad[MASK_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_mask <= n_mask;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.pressed_mask = r_mask;

`ifndef SYNTHESIS
    a_hold_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_time) && $stable(r_pins)))
        else $error("held sample changed before it was processed");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed sample produced no result");

    a_cfg_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> (r_ticks == $past(i_cfg.data)))
        else $error("debounce setting not loaded");
`endif

endmodule
